### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms for the row wrapper modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

### rtl/core/earw_pkg.sv
// ----------------------------------------------------------------------------
// earw_pkg
// types and constants shared by the escape-aware row wrapper
// ----------------------------------------------------------------------------
`default_nettype none

package earw_pkg;

  localparam int unsigned ROW_WIDTH_BITS = 10;
  localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = 10'd80;

  localparam logic [7:0] ESC_BYTE   = 8'h1b;
  localparam logic [7:0] CSI_INTRO  = 8'h5b;
  localparam logic [7:0] FINAL_LO   = 8'h40;
  localparam logic [7:0] FINAL_HI   = 8'h7e;
  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hbf;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_CSI    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    SRC_IN_BYTE   = 2'd0,
    SRC_BREAK     = 2'd1,
    SRC_REPLAY    = 2'd2,
    SRC_HELD_BYTE = 2'd3
  } src_t;

  typedef struct packed {
    logic accept;
    logic emit;
    src_t src;
    logic last;
    logic start;
    logic step;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic has_byte;
    logic line_end;
    logic need_break;
    logic held_line_end;
    logic replay_last;
    logic active_empty;
  } status_t;

endpackage

`default_nettype wire

### rtl/core/escape_aware_row_wrapper.sv
// ----------------------------------------------------------------------------
// escape_aware_row_wrapper
// wraps one logical terminal line into rows, replaying the last csi per row
// ----------------------------------------------------------------------------
// Each input transaction carries at most one byte and a line-end mark. A
// byte that needs no wrap goes straight to the output register, so plain
// text, escape sequences and utf-8 continuation bytes stream at one byte per
// clock while the output is free. A printable byte that hits the row width
// gives the row break, then the L bytes of the remembered csi, read from the
// two-bank sequence memory one per cycle while the output is free, then the
// byte itself. A line end that comes with a byte adds a row break after it.
// Only one transaction is worked on at a time, and a single output register
// bounds the flow. The sequence memory needs no clearing pass after reset.
// Write row_width only while the block is idle; zero counts as one.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_aware_row_wrapper #(
  parameter int unsigned SEQ_MAX  = 32,
  parameter int unsigned COL_BITS = 10
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [9:0] cfg_wr_data,    // row_width
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // data_byte
  input  wire logic [0:0] s_axis_tuser,   // has_byte
  input  wire logic       s_axis_tlast,   // line_end
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // out_byte
  output logic [1:0]      m_axis_tuser,   // kind, sgr_overflow
  output logic            m_axis_tlast    // final_res
);

  earw_pkg::cmd_t    cmd;
  earw_pkg::status_t status;
  logic              out_kind;
  logic              out_ovf;

  earw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .cmd      (cmd),
    .in_ready (s_axis_tready)
  );

  earw_dp #(
    .SEQ_MAX  (SEQ_MAX),
    .COL_BITS (COL_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_has_byte (s_axis_tuser[0]),
    .in_byte     (s_axis_tdata),
    .in_line_end (s_axis_tlast),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_kind    (out_kind),
    .out_byte    (m_axis_tdata),
    .out_ovf     (out_ovf),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tuser = {out_ovf, out_kind};

endmodule

`default_nettype wire

### rtl/core/earw_ctrl.sv
// ----------------------------------------------------------------------------
// earw_ctrl
// sequences the results of one input transaction: byte, row break, replay
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module earw_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire earw_pkg::status_t status,
  output earw_pkg::cmd_t        cmd,
  output logic                  in_ready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPLAY,
    ST_BYTE,
    ST_LEND
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.src    = earw_pkg::SRC_BREAK;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        in_ready = status.out_free;
        if (status.in_valid && status.out_free) begin
          cmd.accept = 1'b1;
          if (status.has_byte) begin
            cmd.emit = 1'b1;
            if (status.need_break) begin
              cmd.src    = earw_pkg::SRC_BREAK;
              cmd.start  = 1'b1;
              state_next = status.active_empty ? ST_BYTE : ST_REPLAY;
            end else begin
              cmd.src  = earw_pkg::SRC_IN_BYTE;
              cmd.last = !status.line_end;
              if (status.line_end) begin
                state_next = ST_LEND;
              end
            end
          end else if (status.line_end) begin
            cmd.emit  = 1'b1;
            cmd.src   = earw_pkg::SRC_BREAK;
            cmd.last  = 1'b1;
            cmd.clear = 1'b1;
          end
        end
      end
      ST_REPLAY: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.src  = earw_pkg::SRC_REPLAY;
          cmd.step = 1'b1;
          if (status.replay_last) begin
            state_next = ST_BYTE;
          end
        end
      end
      ST_BYTE: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.src  = earw_pkg::SRC_HELD_BYTE;
          cmd.last = !status.held_line_end;
          state_next = status.held_line_end ? ST_LEND : ST_IDLE;
        end
      end
      ST_LEND: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.src    = earw_pkg::SRC_BREAK;
          cmd.last   = 1'b1;
          cmd.clear  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ASSERT_IMPL(a_emit_needs_room, clk, rst, cmd.emit, status.out_free)
  `ASSERT_IMPL(a_replay_nonempty, clk, rst, state == ST_REPLAY, !status.active_empty)
  `ASSERT_NEXT(a_break_then_row, clk, rst, cmd.start, (state == ST_REPLAY) || (state == ST_BYTE))

endmodule

`default_nettype wire

### rtl/core/earw_dp.sv
// ----------------------------------------------------------------------------
// earw_dp
// parse state, column count, sequence store and output register
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module earw_dp #(
  parameter int unsigned SEQ_MAX  = 32,
  parameter int unsigned COL_BITS = 10
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [earw_pkg::ROW_WIDTH_BITS-1:0] cfg_wr_data,
  input  wire logic                                in_valid,
  input  wire logic                                in_has_byte,
  input  wire logic [7:0]                          in_byte,
  input  wire logic                                in_line_end,
  input  wire earw_pkg::cmd_t                      cmd,
  output earw_pkg::status_t                        status,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic                                     out_kind,
  output logic [7:0]                               out_byte,
  output logic                                     out_ovf,
  output logic                                     out_last
);

  localparam int unsigned IW   = $clog2(SEQ_MAX);
  localparam int unsigned LENW = $clog2(SEQ_MAX + 1);
  localparam int unsigned LW   = (COL_BITS > earw_pkg::ROW_WIDTH_BITS) ?
                                 COL_BITS : earw_pkg::ROW_WIDTH_BITS;
  localparam logic [COL_BITS-1:0] COL_MAX = '1;

  logic [earw_pkg::ROW_WIDTH_BITS-1:0] row_width;
  earw_pkg::mode_t     mode;
  logic [COL_BITS-1:0] column;
  logic                act_bank;
  logic [LENW-1:0]     act_len;
  logic [LENW-1:0]     cap_len;
  logic                cap_long;
  logic [IW-1:0]       idx;
  logic [7:0]          held_byte;
  logic                held_line_end;
  logic [7:0]          rd_data;
  logic [7:0]          seq_mem [2][SEQ_MAX];

  logic            mode_esc, mode_csi, mode_normal;
  logic            is_esc, is_intro, is_final, is_cont;
  logic            printable, need_break;
  logic [LW-1:0]   limit_raw, limit;
  logic            push, push_fits, csi_done, ovf_now;
  logic [LENW-1:0] push_base, cap_len_after;
  logic            long_base, long_after;
  logic            replay_last;
  logic [IW-1:0]   rd_idx;
  logic            out_free;
  earw_pkg::mode_t mode_next;

  assign mode_esc    = (mode == earw_pkg::MODE_ESC);
  assign mode_csi    = (mode == earw_pkg::MODE_CSI);
  assign mode_normal = !mode_esc && !mode_csi;

  assign is_esc   = (in_byte == earw_pkg::ESC_BYTE);
  assign is_intro = (in_byte == earw_pkg::CSI_INTRO);
  assign is_final = (in_byte >= earw_pkg::FINAL_LO) && (in_byte <= earw_pkg::FINAL_HI);
  assign is_cont  = (in_byte >= earw_pkg::CONT_LO) && (in_byte <= earw_pkg::CONT_HI);

  assign printable = mode_normal && !is_esc && !is_cont;
  assign limit_raw = (row_width == '0) ? LW'(1) : LW'(row_width);
  assign limit     = (limit_raw > LW'(COL_MAX)) ? LW'(COL_MAX) : limit_raw;
  assign need_break = printable && (LW'(column) >= limit);

  assign push = (mode_esc && is_intro) || mode_csi || (mode_normal && is_esc);
  assign push_base = (mode_normal && is_esc) ? '0 : cap_len;
  assign long_base = (mode_normal && is_esc) ? 1'b0 : cap_long;
  assign push_fits = push_base < LENW'(SEQ_MAX);
  assign cap_len_after = push_fits ? push_base + LENW'(1) : push_base;
  assign long_after = long_base || !push_fits;
  assign csi_done = mode_csi && is_final;
  assign ovf_now  = csi_done && cap_long;

  always_comb begin
    case (mode)
      earw_pkg::MODE_ESC: mode_next = is_intro ? earw_pkg::MODE_CSI : earw_pkg::MODE_NORMAL;
      earw_pkg::MODE_CSI: mode_next = is_final ? earw_pkg::MODE_NORMAL : earw_pkg::MODE_CSI;
      default:            mode_next = is_esc ? earw_pkg::MODE_ESC : earw_pkg::MODE_NORMAL;
    endcase
  end

  assign replay_last = (LENW'(idx) + LENW'(1)) == act_len;
  assign out_free    = !out_valid || out_ready;

  always_comb begin
    if (cmd.start) begin
      rd_idx = '0;
    end else if (cmd.step && !replay_last) begin
      rd_idx = idx + IW'(1);
    end else begin
      rd_idx = idx;
    end
  end

  assign status.in_valid      = in_valid;
  assign status.out_free      = out_free;
  assign status.has_byte      = in_has_byte;
  assign status.line_end      = in_line_end;
  assign status.need_break    = need_break;
  assign status.held_line_end = held_line_end;
  assign status.replay_last   = replay_last;
  assign status.active_empty  = (act_len == '0);

  // sequence store: capture fills the bank that is not being replayed
  always_ff @(posedge clk) begin
    if (cmd.accept && in_has_byte && push && push_fits) begin
      seq_mem[!act_bank][push_base[IW-1:0]] <= in_byte;
    end
    rd_data <= seq_mem[act_bank][rd_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      held_byte     <= in_byte;
      held_line_end <= in_line_end;
    end
    if (cmd.start) begin
      idx <= '0;
    end else if (cmd.step && !replay_last) begin
      idx <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= earw_pkg::ROW_WIDTH_RESET;
      mode      <= earw_pkg::MODE_NORMAL;
      column    <= '0;
      act_bank  <= 1'b0;
      act_len   <= '0;
      cap_len   <= '0;
      cap_long  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        row_width <= cfg_wr_data;
      end
      if (cmd.clear) begin
        mode     <= earw_pkg::MODE_NORMAL;
        column   <= '0;
        act_len  <= '0;
        cap_len  <= '0;
        cap_long <= 1'b0;
      end else if (cmd.accept && in_has_byte) begin
        mode <= mode_next;
        if (push) begin
          if (csi_done) begin
            if (!long_after) begin
              act_bank <= !act_bank;
              act_len  <= cap_len_after;
            end
            cap_len  <= '0;
            cap_long <= 1'b0;
          end else begin
            cap_len  <= cap_len_after;
            cap_long <= long_after;
          end
        end
        if (printable) begin
          if (need_break) begin
            column <= COL_BITS'(1);
          end else if (column != COL_MAX) begin
            column <= column + COL_BITS'(1);
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last <= cmd.last;
      case (cmd.src)
        earw_pkg::SRC_IN_BYTE: begin
          out_kind <= 1'b0;
          out_byte <= in_byte;
          out_ovf  <= ovf_now;
        end
        earw_pkg::SRC_REPLAY: begin
          out_kind <= 1'b0;
          out_byte <= rd_data;
          out_ovf  <= 1'b0;
        end
        earw_pkg::SRC_HELD_BYTE: begin
          out_kind <= 1'b0;
          out_byte <= held_byte;
          out_ovf  <= 1'b0;
        end
        default: begin
          out_kind <= 1'b1;
          out_byte <= '0;
          out_ovf  <= 1'b0;
        end
      endcase
    end
  end

  `ASSERT_IMPL(a_len_bound, clk, rst, 1'b1, (act_len <= LENW'(SEQ_MAX)) && (cap_len <= LENW'(SEQ_MAX)))
  `ASSERT_NEXT(a_clear_state, clk, rst, cmd.clear, (act_len == '0) && (cap_len == '0) && (column == '0))

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// row wrapper check: a directed byte table, then random terminal lines built
// from text, csi and two-byte escapes, utf-8 continuation bytes and broken
// sequences, over several row widths, with both stream sides idling at random.
// every output transaction is compared with the directed table or an in-bench wrap predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEQ_DEPTH = 32;
  localparam int GAP_MAX = 17;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int N_PHASES = 8;
  localparam int PHASE_ITEMS = 40;
  localparam logic [9:0] COL_LIMIT = 10'h3ff;
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_BREAK = 1'b1;

  typedef struct packed {
    logic       has;
    logic [7:0] data;
    logic       le;
  } wrap_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] obyte;
    logic       ovf;
    logic       fin;
  } row_out_t;

  typedef struct packed {
    wrap_item_t item;
    logic       typed;
    logic       one;
    logic       kind;
    logic [7:0] obyte;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [0:24] = '{
    '{'{1'b0, 8'h00, 1'b0}, 1'b1, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b0, 8'h00, 1'b1}, 1'b1, 1'b1, KIND_BREAK, 8'h00},
    '{'{1'b1, 8'h41, 1'b0}, 1'b1, 1'b1, KIND_BYTE, 8'h41},
    '{'{1'b1, 8'h00, 1'b0}, 1'b0, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b1, 8'hff, 1'b0}, 1'b0, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b1, earw_pkg::CONT_LO, 1'b0}, 1'b0, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b1, earw_pkg::CONT_HI, 1'b0}, 1'b0, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b1, earw_pkg::ESC_BYTE, 1'b0}, 1'b0, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b1, earw_pkg::CSI_INTRO, 1'b0}, 1'b0, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b1, earw_pkg::FINAL_HI, 1'b0}, 1'b0, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b1, earw_pkg::ESC_BYTE, 1'b0}, 1'b0, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b1, earw_pkg::CSI_INTRO, 1'b0}, 1'b0, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b1, 8'h31, 1'b0}, 1'b0, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b1, earw_pkg::FINAL_LO, 1'b0}, 1'b0, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b1, 8'h7f, 1'b0}, 1'b0, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b1, 8'h62, 1'b0}, 1'b0, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b1, earw_pkg::ESC_BYTE, 1'b0}, 1'b0, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b1, earw_pkg::ESC_BYTE, 1'b0}, 1'b0, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b1, 8'h71, 1'b0}, 1'b0, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b1, earw_pkg::ESC_BYTE, 1'b0}, 1'b0, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b1, earw_pkg::CSI_INTRO, 1'b0}, 1'b0, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b1, 8'h32, 1'b1}, 1'b0, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b1, 8'h63, 1'b1}, 1'b0, 1'b0, KIND_BYTE, 8'h00},
    '{'{1'b1, 8'h7e, 1'b0}, 1'b1, 1'b1, KIND_BYTE, 8'h7e},
    '{'{1'b0, 8'hff, 1'b1}, 1'b1, 1'b1, KIND_BREAK, 8'h00}
  };

  localparam logic [9:0] PHASE_WIDTH [0:N_PHASES-1] = '{
    10'd1, 10'd0, 10'd5, 10'd1023, 10'd80, 10'd12, 10'd2, 10'd33
  };

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [9:0] cfg_wr_data;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic [0:0] s_axis_tuser;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  // wrap predictor state
  logic [9:0]        width_m;
  earw_pkg::mode_t   mode_m;
  logic [9:0]        col_m;
  logic [7:0]        act_seq [SEQ_DEPTH];
  logic [7:0]        cap_seq [SEQ_DEPTH];
  int                act_len;
  int                cap_len;
  bit                cap_long;

  row_out_t   step_rows_q[$];
  row_out_t   row_expect_q[$];
  wrap_item_t line_q[$];

  bit tx_fast;
  bit rx_fast;
  bit hold_req;
  int n_items;
  int n_results;
  int n_wraps;
  int n_ovf;
  int n_holds;
  int n_errors;

  escape_aware_row_wrapper u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("[escape_aware_row_wrapper] ERROR");
    $finish;
  end

  function automatic int pick_gap(input bit fast);
    return fast ? 0 : int'($urandom_range(0, GAP_MAX));
  endfunction

  function automatic logic [7:0] pick_print();
    logic [7:0] b;
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(8'h7e, 8'h20));
    do b = 8'($urandom);
    while (b == earw_pkg::ESC_BYTE ||
           (b >= earw_pkg::CONT_LO && b <= earw_pkg::CONT_HI));
    return b;
  endfunction

  task automatic clear_line_state();
    mode_m = earw_pkg::MODE_NORMAL;
    col_m = '0;
    act_len = 0;
    cap_len = 0;
    cap_long = 1'b0;
  endtask

  task automatic emit_row(input logic kind, input logic [7:0] b, input logic ovf);
    step_rows_q.insert(step_rows_q.size(), '{kind, b, ovf, 1'b0});
  endtask

  task automatic push_capture(input logic [7:0] b);
    if (cap_len < SEQ_DEPTH) begin
      cap_seq[cap_len] = b;
      cap_len++;
    end else begin
      cap_long = 1'b1;
    end
  endtask

  task automatic wrap_byte(input logic [7:0] b);
    logic [9:0] lim;
    case (mode_m)
      earw_pkg::MODE_ESC: begin
        emit_row(KIND_BYTE, b, 1'b0);
        if (b == earw_pkg::CSI_INTRO) begin
          push_capture(b);
          mode_m = earw_pkg::MODE_CSI;
        end else begin
          mode_m = earw_pkg::MODE_NORMAL;
        end
      end
      earw_pkg::MODE_CSI: begin
        if (b >= earw_pkg::FINAL_LO && b <= earw_pkg::FINAL_HI) begin
          emit_row(KIND_BYTE, b, cap_long);
          push_capture(b);
          if (!cap_long) begin
            for (int i = 0; i < cap_len; i++) act_seq[i] = cap_seq[i];
            act_len = cap_len;
          end
          cap_len = 0;
          cap_long = 1'b0;
          mode_m = earw_pkg::MODE_NORMAL;
        end else begin
          emit_row(KIND_BYTE, b, 1'b0);
          push_capture(b);
        end
      end
      default: begin
        mode_m = earw_pkg::MODE_NORMAL;
        if (b == earw_pkg::ESC_BYTE) begin
          emit_row(KIND_BYTE, b, 1'b0);
          cap_len = 0;
          cap_long = 1'b0;
          push_capture(b);
          mode_m = earw_pkg::MODE_ESC;
        end else if (b >= earw_pkg::CONT_LO && b <= earw_pkg::CONT_HI) begin
          emit_row(KIND_BYTE, b, 1'b0);
        end else begin
          lim = (width_m == '0) ? 10'd1 : width_m;
          if (col_m >= lim) begin
            emit_row(KIND_BREAK, 8'h00, 1'b0);
            for (int i = 0; i < act_len; i++) emit_row(KIND_BYTE, act_seq[i], 1'b0);
            col_m = '0;
            n_wraps++;
          end
          emit_row(KIND_BYTE, b, 1'b0);
          if (col_m < COL_LIMIT) col_m++;
        end
      end
    endcase
  endtask

  task automatic predict_rows(input wrap_item_t it);
    step_rows_q.delete();
    if (it.has) wrap_byte(it.data);
    if (it.le) begin
      emit_row(KIND_BREAK, 8'h00, 1'b0);
      clear_line_state();
    end
    if (step_rows_q.size() > 0) begin
      step_rows_q[step_rows_q.size()-1].fin = 1'b1;
    end
  endtask

  task automatic send_item(input wrap_item_t it, input int gap, input bit typed,
                           input bit one, input row_out_t want);
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= it.data;
    s_axis_tuser <= it.has;
    s_axis_tlast <= it.le;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    predict_rows(it);
    if (typed) begin
      if (one) row_expect_q.insert(row_expect_q.size(), want);
    end else begin
      foreach (step_rows_q[i]) row_expect_q.insert(row_expect_q.size(), step_rows_q[i]);
    end
    n_items++;
  endtask

  task automatic set_width(input logic [9:0] w);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    width_m = w;
  endtask

  task automatic wait_rows_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (row_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_byte(input logic [7:0] b);
    line_q.insert(line_q.size(), '{1'b1, b, 1'b0});
  endtask

  task automatic add_csi(input int n_params);
    add_byte(earw_pkg::ESC_BYTE);
    add_byte(earw_pkg::CSI_INTRO);
    repeat (n_params) add_byte(8'($urandom_range(8'h3f, 8'h20)));
    add_byte(8'($urandom_range(earw_pkg::FINAL_HI, earw_pkg::FINAL_LO)));
  endtask

  task automatic close_line();
    if (line_q.size() > 0 && line_q[line_q.size()-1].has && $urandom_range(0, 1)) begin
      line_q[line_q.size()-1].le = 1'b1;
    end else begin
      line_q.insert(line_q.size(), '{1'b0, 8'($urandom), 1'b1});
    end
  endtask

  task automatic build_line();
    int n_seg;
    int r;
    bit cut;
    logic [7:0] b;
    line_q.delete();
    cut = 1'b0;
    n_seg = $urandom_range(1, 10);
    for (int s = 0; s < n_seg && !cut; s++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        repeat ($urandom_range(1, 6)) add_byte(pick_print());
      end else if (r < 56) begin
        repeat ($urandom_range(1, 3))
          add_byte(8'($urandom_range(earw_pkg::CONT_HI, earw_pkg::CONT_LO)));
      end else if (r < 70) begin
        add_csi($urandom_range(0, 5));
      end else if (r < 72) begin
        add_csi($urandom_range(28, 34));
      end else if (r < 80) begin
        add_byte(earw_pkg::ESC_BYTE);
        do b = 8'($urandom); while (b == earw_pkg::CSI_INTRO);
        add_byte(b);
      end else if (r < 84) begin
        add_byte(earw_pkg::ESC_BYTE);
        add_byte(earw_pkg::ESC_BYTE);
      end else if (r < 89) begin
        add_byte(8'($urandom));
      end else if (r < 94) begin
        line_q.insert(line_q.size(), '{1'b0, 8'($urandom), 1'b0});
      end else begin
        // sequence cut off by the line end
        add_byte(earw_pkg::ESC_BYTE);
        if ($urandom_range(0, 1)) begin
          add_byte(earw_pkg::CSI_INTRO);
          repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(8'h3f, 8'h20)));
        end
        cut = 1'b1;
      end
    end
    close_line();
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_item(line_q[i], pick_gap(tx_fast), 1'b0, 1'b0, '0);
  endtask

  task automatic check_row_out();
    row_out_t want;
    n_results++;
    if (m_axis_tuser[1] === 1'b1) n_ovf++;
    if (row_expect_q.size() == 0) begin
      $error("unexpected transaction: kind %0d out_byte %02h", m_axis_tuser[0], m_axis_tdata);
      n_errors++;
    end else begin
      want = row_expect_q.pop_front();
      if (m_axis_tuser[0] !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, m_axis_tuser[0]);
        n_errors++;
      end
      if (m_axis_tdata !== want.obyte) begin
        $error("out_byte: expected %02h, actual %02h", want.obyte, m_axis_tdata);
        n_errors++;
      end
      if (m_axis_tuser[1] !== want.ovf) begin
        $error("sgr_overflow: expected %0d, actual %0d", want.ovf, m_axis_tuser[1]);
        n_errors++;
      end
      if (m_axis_tlast !== want.fin) begin
        $error("final_res: expected %0d, actual %0d", want.fin, m_axis_tlast);
        n_errors++;
      end
    end
  endtask

  // receiver
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk);
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        n_holds++;
      end
      gap = pick_gap(rx_fast);
      repeat (gap) begin
        @(negedge clk);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk);
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      check_row_out();
    end
  end

  // sender and phase control
  initial begin
    int start_items;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    tx_fast = 1'b0;
    rx_fast = 1'b0;
    hold_req = 1'b0;
    width_m = earw_pkg::ROW_WIDTH_RESET;
    clear_line_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_width(10'd2);
    for (int i = 0; i < $size(DIR_TAB); i++) begin
      send_item(DIR_TAB[i].item, pick_gap(1'b0), DIR_TAB[i].typed, DIR_TAB[i].one,
                '{DIR_TAB[i].kind, DIR_TAB[i].obyte, 1'b0, 1'b1});
    end
    wait_rows_drained();

    for (int p = 0; p < N_PHASES; p++) begin
      set_width(PHASE_WIDTH[p]);
      tx_fast = (p == 4) || (p == 6);
      rx_fast = (p == 4) || (p == 5);
      if (p == 2) hold_req = 1'b1;
      start_items = n_items;
      if (p == 0 || p == 5) begin
        // csi that just fits, then one that overruns the store
        line_q.delete();
        add_csi(29);
        repeat (3) add_byte(pick_print());
        add_csi(30);
        repeat (3) add_byte(pick_print());
        close_line();
        send_line();
      end
      while (n_items - start_items < PHASE_ITEMS) begin
        build_line();
        send_line();
      end
      wait_rows_drained();
    end

    $display("covered %0d input transactions over %0d width settings, %0d output transactions",
             n_items, N_PHASES + 1, n_results);
    $display("%0d row wraps, %0d overlong csi marks, %0d long receiver holds",
             n_wraps, n_ovf, n_holds);
    if (n_errors == 0) begin
      $display("[escape_aware_row_wrapper] OK");
    end else begin
      $display("[escape_aware_row_wrapper] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+rtl/core
rtl/core/earw_pkg.sv
rtl/core/earw_ctrl.sv
rtl/core/earw_dp.sv
rtl/core/escape_aware_row_wrapper.sv
tb/sv/tb_top.sv
